[sv/bgrc_pkg.sv]
package bgrc_pkg;

    // Line limits of the grid; a register value above the limit acts as the limit.
    localparam int MAX_COLS   = 64;
    localparam int MAX_ROWS   = 64;
    localparam int LINE_CAP   = 64;
    localparam int COL_LIMIT  = (MAX_COLS < LINE_CAP) ? MAX_COLS : LINE_CAP;
    localparam int ROW_LIMIT  = (MAX_ROWS < LINE_CAP) ? MAX_ROWS : LINE_CAP;

    // Fixed field widths.
    localparam int POS_W      = 6;
    localparam int LEN_W      = 7;
    localparam int CNT_W      = 6;
    localparam int BYTE_W     = 8;
    localparam int IDX_W      = 2;

    localparam logic [BYTE_W-1:0] FILLED_CODE = 8'h01;

    localparam logic [IDX_W-1:0] CFG_COLS = 2'd0;
    localparam logic [IDX_W-1:0] CFG_ROWS = 2'd1;

    typedef enum logic [1:0] {
        KIND_ROW = 2'd0,
        KIND_COL = 2'd1,
        KIND_SUM = 2'd2
    } kind_t;

    // One entry of the column store: clue count above the open run length.
    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic [LEN_W-1:0] run;
    } col_entry_t;

    localparam int ENTRY_W = $bits(col_entry_t);

endpackage

[sv/bgrc_ram.sv]
module bgrc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        // Read data holds until the next read.
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[sv/binary_grid_run_clue_extractor.sv]
// Channel  | Handshake                  | Word
// ---------+----------------------------+-------------------------------------------------
// input    | in_valid / in_stall        | cell_byte
// output   | out_valid / out_stall      | clue_kind, line_index, run_length,
//          |                            | max_row_clues, max_col_clues, last_of_item
// config   | cfg_write (no wait)        | cfg_index, cfg_data
//
// A cell is taken every cycle as long as the result words of the cell ahead of it
// fit: each cell produces up to three words and the output drains one word a cycle
// while out_stall is low; a waiting cell holds the input until only the last word
// ahead of it remains and is being taken. Between the edge that accepts a cell and
// its first result word lie the registered read of the column store and then the
// result register.
// rst_n clears all control state at once; the column store needs no clearing
// because row 0 of every grid initializes each entry before it is read.
// in_stall rises only while a cell waits for the output words ahead of it to drain.
module binary_grid_run_clue_extractor (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            cfg_write,
    input  logic [bgrc_pkg::IDX_W-1:0]      cfg_index,
    input  logic [bgrc_pkg::LEN_W-1:0]      cfg_data,

    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [bgrc_pkg::BYTE_W-1:0]     cell_byte,

    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [1:0]                      clue_kind,
    output logic [bgrc_pkg::POS_W-1:0]      line_index,
    output logic [bgrc_pkg::LEN_W-1:0]      run_length,
    output logic [bgrc_pkg::CNT_W-1:0]      max_row_clues,
    output logic [bgrc_pkg::CNT_W-1:0]      max_col_clues,
    output logic                            last_of_item
);

    localparam int POS_W = bgrc_pkg::POS_W;
    localparam int LEN_W = bgrc_pkg::LEN_W;
    localparam int CNT_W = bgrc_pkg::CNT_W;

    // Configuration registers.
    logic [LEN_W-1:0] cols_reg;
    logic [LEN_W-1:0] rows_reg;
    logic [LEN_W-1:0] cols_eff;
    logic [LEN_W-1:0] rows_eff;

    // Position of the next cell, advanced when a cell is accepted.
    logic [POS_W-1:0] col_pos_reg;
    logic [POS_W-1:0] col_pos_next;
    logic [POS_W-1:0] row_pos_reg;
    logic [POS_W-1:0] row_pos_next;

    // Row and grid counters, advanced when a cell leaves the read stage.
    logic [LEN_W-1:0] row_run_reg;
    logic [LEN_W-1:0] row_run_next;
    logic [CNT_W-1:0] row_cnt_reg;
    logic [CNT_W-1:0] row_cnt_next;
    logic [CNT_W-1:0] row_max_reg;
    logic [CNT_W-1:0] row_max_next;
    logic [CNT_W-1:0] col_max_reg;
    logic [CNT_W-1:0] col_max_next;

    // Read stage: the cell whose column entry is being read.
    logic                    s1_valid_reg;
    logic                    s1_filled_reg;
    logic [POS_W-1:0]        s1_c_reg;
    logic [POS_W-1:0]        s1_r_reg;
    logic                    s1_row_end_reg;
    logic                    s1_col_end_reg;
    logic                    s1_fwd_reg;
    bgrc_pkg::col_entry_t    s1_fwd_data_reg;

    // Result group of the last cell that left the read stage.
    logic                    grp_row_vld_reg;
    logic [POS_W-1:0]        grp_row_idx_reg;
    logic [LEN_W-1:0]        grp_row_len_reg;
    logic                    grp_col_vld_reg;
    logic [POS_W-1:0]        grp_col_idx_reg;
    logic [LEN_W-1:0]        grp_col_len_reg;
    logic                    grp_sum_vld_reg;
    logic [CNT_W-1:0]        grp_sum_mr_reg;
    logic [CNT_W-1:0]        grp_sum_mc_reg;

    logic                    in_accept;
    logic                    out_accept;
    logic                    advance;
    logic [1:0]              grp_count;

    logic [POS_W-1:0]        c_in;
    logic [POS_W-1:0]        r_in;
    logic                    row_end_in;
    logic                    col_end_in;

    bgrc_pkg::col_entry_t    ram_rd_data;
    bgrc_pkg::col_entry_t    ram_wr_data;
    bgrc_pkg::col_entry_t    col_old;

    logic                    row_vld;
    logic [LEN_W-1:0]        row_len;
    logic                    col_vld;
    logic [LEN_W-1:0]        col_len;
    logic                    sum_vld;

    // Register values of 0 act as 1; values above the line limit act as the limit.
    always_comb
    begin
        if (cols_reg == '0)
            cols_eff = LEN_W'(1);
        else if (cols_reg > LEN_W'(bgrc_pkg::COL_LIMIT))
            cols_eff = LEN_W'(bgrc_pkg::COL_LIMIT);
        else
            cols_eff = cols_reg;

        if (rows_reg == '0)
            rows_eff = LEN_W'(1);
        else if (rows_reg > LEN_W'(bgrc_pkg::ROW_LIMIT))
            rows_eff = LEN_W'(bgrc_pkg::ROW_LIMIT);
        else
            rows_eff = rows_reg;
    end

    // Position of the incoming cell and where the next one lands.
    always_comb
    begin
        c_in       = ({1'b0, col_pos_reg} < cols_eff) ? col_pos_reg : '0;
        r_in       = ({1'b0, row_pos_reg} < rows_eff) ? row_pos_reg : '0;
        row_end_in = ({1'b0, c_in} == (cols_eff - LEN_W'(1)));
        col_end_in = ({1'b0, r_in} == (rows_eff - LEN_W'(1)));

        col_pos_next = col_pos_reg;
        row_pos_next = row_pos_reg;
        if (in_accept)
        begin
            if (row_end_in)
            begin
                col_pos_next = '0;
                row_pos_next = col_end_in ? '0 : r_in + POS_W'(1);
            end
            else
            begin
                col_pos_next = c_in + POS_W'(1);
                row_pos_next = r_in;
            end
        end
    end

    // The read stage moves on once the result group will be empty this cycle.
    assign grp_count  = 2'(grp_row_vld_reg) + 2'(grp_col_vld_reg) + 2'(grp_sum_vld_reg);
    assign out_valid  = (grp_count != 2'd0);
    assign out_accept = out_valid && !out_stall;
    assign advance    = s1_valid_reg &&
                        ((grp_count == 2'd0) || ((grp_count == 2'd1) && out_accept));
    assign in_stall   = s1_valid_reg && !advance;
    assign in_accept  = in_valid && !in_stall;

    // Column entry of the cell in the read stage: row 0 starts fresh, and a write
    // to the same column in the cycle of the read is forwarded.
    always_comb
    begin
        if (s1_r_reg == '0)
            col_old = '0;
        else if (s1_fwd_reg)
            col_old = s1_fwd_data_reg;
        else
            col_old = ram_rd_data;
    end

    // Run tracking of the row and of the column for the cell in the read stage.
    always_comb
    begin
        logic [LEN_W-1:0] rrun;
        logic [CNT_W-1:0] rcnt;
        logic [LEN_W-1:0] crun;
        logic [CNT_W-1:0] ccnt;

        rrun    = row_run_reg;
        rcnt    = row_cnt_reg;
        row_vld = 1'b0;
        row_len = '0;
        if (s1_filled_reg)
        begin
            rrun = rrun + LEN_W'(1);
        end
        else if (rrun != '0)
        begin
            row_vld = 1'b1;
            row_len = rrun;
            rcnt    = rcnt + CNT_W'(1);
            rrun    = '0;
        end
        row_max_next = row_max_reg;
        if (s1_row_end_reg)
        begin
            if (rrun != '0)
            begin
                row_vld = 1'b1;
                row_len = rrun;
                rcnt    = rcnt + CNT_W'(1);
                rrun    = '0;
            end
            if (rcnt == '0)
            begin
                row_vld = 1'b1;
                row_len = '0;
            end
            if (rcnt > row_max_reg)
                row_max_next = rcnt;
            rcnt = '0;
        end
        row_run_next = rrun;
        row_cnt_next = rcnt;

        crun    = col_old.run;
        ccnt    = col_old.cnt;
        col_vld = 1'b0;
        col_len = '0;
        if (s1_filled_reg)
        begin
            crun = crun + LEN_W'(1);
        end
        else if (crun != '0)
        begin
            col_vld = 1'b1;
            col_len = crun;
            ccnt    = ccnt + CNT_W'(1);
            crun    = '0;
        end
        col_max_next = col_max_reg;
        if (s1_col_end_reg)
        begin
            if (crun != '0)
            begin
                col_vld = 1'b1;
                col_len = crun;
                ccnt    = ccnt + CNT_W'(1);
                crun    = '0;
            end
            if (ccnt == '0)
            begin
                col_vld = 1'b1;
                col_len = '0;
            end
            if (ccnt > col_max_reg)
                col_max_next = ccnt;
        end
        ram_wr_data.run = crun;
        ram_wr_data.cnt = ccnt;

        sum_vld = s1_row_end_reg && s1_col_end_reg;
    end

    bgrc_ram #(
        .WIDTH (bgrc_pkg::ENTRY_W),
        .DEPTH (bgrc_pkg::COL_LIMIT)
    ) u_col_store (
        .clk     (clk),
        .wr_en   (advance),
        .wr_addr (s1_c_reg),
        .wr_data (ram_wr_data),
        .rd_en   (in_accept),
        .rd_addr (c_in),
        .rd_data (ram_rd_data)
    );

    // Configuration, positions and counters. Any register write restarts the grid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg    <= LEN_W'(64);
            rows_reg    <= LEN_W'(64);
            col_pos_reg <= '0;
            row_pos_reg <= '0;
            row_run_reg <= '0;
            row_cnt_reg <= '0;
            row_max_reg <= '0;
            col_max_reg <= '0;
        end
        else if (cfg_write &&
                 ((cfg_index == bgrc_pkg::CFG_COLS) || (cfg_index == bgrc_pkg::CFG_ROWS)))
        begin
            if (cfg_index == bgrc_pkg::CFG_COLS)
                cols_reg <= cfg_data;
            else
                rows_reg <= cfg_data;
            col_pos_reg <= '0;
            row_pos_reg <= '0;
            row_run_reg <= '0;
            row_cnt_reg <= '0;
            row_max_reg <= '0;
            col_max_reg <= '0;
        end
        else
        begin
            col_pos_reg <= col_pos_next;
            row_pos_reg <= row_pos_next;
            if (advance)
            begin
                row_run_reg <= row_run_next;
                row_cnt_reg <= row_cnt_next;
                // The grid ends after the summary, so both maxima start over.
                row_max_reg <= sum_vld ? '0 : row_max_next;
                col_max_reg <= sum_vld ? '0 : col_max_next;
            end
        end
    end

    // Read stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // Read stage payload.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_filled_reg   <= (cell_byte == bgrc_pkg::FILLED_CODE);
            s1_c_reg        <= c_in;
            s1_r_reg        <= r_in;
            s1_row_end_reg  <= row_end_in;
            s1_col_end_reg  <= col_end_in;
            s1_fwd_reg      <= advance && (s1_c_reg == c_in);
            s1_fwd_data_reg <= ram_wr_data;
        end
    end

    // Result group valid bits: loaded as a whole, drained one word at a time.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grp_row_vld_reg <= 1'b0;
            grp_col_vld_reg <= 1'b0;
            grp_sum_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            grp_row_vld_reg <= row_vld;
            grp_col_vld_reg <= col_vld;
            grp_sum_vld_reg <= sum_vld;
        end
        else if (out_accept)
        begin
            if (grp_row_vld_reg)
                grp_row_vld_reg <= 1'b0;
            else if (grp_col_vld_reg)
                grp_col_vld_reg <= 1'b0;
            else
                grp_sum_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            grp_row_idx_reg <= s1_r_reg;
            grp_row_len_reg <= row_len;
            grp_col_idx_reg <= s1_c_reg;
            grp_col_len_reg <= col_len;
            grp_sum_mr_reg  <= row_max_next;
            grp_sum_mc_reg  <= col_max_next;
        end
    end

    // Output word: row clue first, then column clue, then the summary.
    always_comb
    begin
        clue_kind     = 2'(bgrc_pkg::KIND_SUM);
        line_index    = '0;
        run_length    = '0;
        max_row_clues = '0;
        max_col_clues = '0;
        if (grp_row_vld_reg)
        begin
            clue_kind  = 2'(bgrc_pkg::KIND_ROW);
            line_index = grp_row_idx_reg;
            run_length = grp_row_len_reg;
        end
        else if (grp_col_vld_reg)
        begin
            clue_kind  = 2'(bgrc_pkg::KIND_COL);
            line_index = grp_col_idx_reg;
            run_length = grp_col_len_reg;
        end
        else
        begin
            max_row_clues = grp_sum_mr_reg;
            max_col_clues = grp_sum_mc_reg;
        end
        last_of_item = (grp_count == 2'd1);
    end

    // A cell read in the cycle its column is written must see the new entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && advance && (s1_c_reg == c_in)) |=> s1_fwd_reg)
        else $error("column store write not forwarded to the following read");

    // A waiting cell keeps its place and position.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !advance) |=> (s1_valid_reg && $stable(s1_c_reg)
                                        && $stable(s1_r_reg)))
        else $error("read stage lost a waiting cell");

    // The end of a grid clears both maxima.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && sum_vld) |=> ((row_max_reg == '0) && (col_max_reg == '0)))
        else $error("maxima not cleared at the end of a grid");

    // A new group is only loaded once the previous one has drained.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |-> ((grp_count == 2'd0) || ((grp_count == 2'd1) && !out_stall)))
        else $error("result group overwritten before it drained");

endmodule
